/* rtl/tfec_pkg.sv */
// Package: shared constants, types and helpers of the typed frame encoder.
`default_nettype none
package tfec_pkg;

  localparam int unsigned COUNT_BITS = 4;

  localparam logic [7:0] CMD_BYTE = 8'h77;

  localparam logic [2:0] KIND_U16 = 3'd0;
  localparam logic [2:0] KIND_I16 = 3'd1;
  localparam logic [2:0] KIND_U32 = 3'd2;
  localparam logic [2:0] KIND_I32 = 3'd3;

  localparam logic [7:0] CODE_U16 = 8'h50;
  localparam logic [7:0] CODE_I16 = 8'h60;
  localparam logic [7:0] CODE_U32 = 8'h70;
  localparam logic [7:0] CODE_I32 = 8'h80;
  localparam logic [7:0] CODE_F32 = 8'hB0;

  localparam logic [2:0] ELEN_NONE  = 3'd0;
  localparam logic [2:0] ELEN_SHORT = 3'd2;
  localparam logic [2:0] ELEN_LONG  = 3'd4;

  localparam logic [3:0] HDR_BYTES = 4'd3;

  // One unit of work for the serializer: optional header, element bytes,
  // optional checksum.
  typedef struct packed {
    logic        hdr;
    logic [7:0]  tl;
    logic [7:0]  addr;
    logic [2:0]  elen;
    logic [31:0] val;
    logic        sum_en;
  } job_t;

  function automatic logic [7:0] type_code(input logic [2:0] kind);
    logic [7:0] code;
    case (kind)
      KIND_U16: code = CODE_U16;
      KIND_I16: code = CODE_I16;
      KIND_U32: code = CODE_U32;
      KIND_I32: code = CODE_I32;
      default:  code = CODE_F32;
    endcase
    return code;
  endfunction

  function automatic logic is_short(input logic [2:0] kind);
    return (kind == KIND_U16) || (kind == KIND_I16);
  endfunction

endpackage
`default_nettype wire

/* rtl/tfec_if.sv */
// Interfaces: input item channel and output byte channel.
`default_nettype none
interface tfec_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  element_kind;
  logic [3:0]  element_count;
  logic [7:0]  target_address;
  logic [31:0] element_value;

  modport source (output valid, element_kind, element_count, target_address,
                  element_value, input ready);
  modport sink (input valid, element_kind, element_count, target_address,
                element_value, output ready);
endinterface

interface tfec_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       frame_end;

  modport source (output valid, out_byte, last_of_run, frame_end, input ready);
  modport sink (input valid, out_byte, last_of_run, frame_end, output ready);
endinterface
`default_nettype wire

/* rtl/typed_frame_encoder_checksum.sv */
// Top level: typed write-frame encoder with trailing byte checksum.
// The first byte of an item passes through the job queue and then the output
//   register before it reaches the link.
// One byte per cycle on the link while the receiver is ready; an item's element
//   is 2 or 4 bytes, plus 3 for a frame header and 1 for a checksum.
// The input takes a new item every cycle while the two-entry job queue has room.
// Reset (async, active low) closes any open frame, empties the queue and output.
`default_nettype none
module typed_frame_encoder_checksum (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tfec_in_if.sink   in_i,
  tfec_out_if.source out_o
);

  // Front end to queue.
  tfec_pkg::job_t push_job;
  logic           push;
  logic           full;

  // Queue to serializer.
  tfec_pkg::job_t pop_job;
  logic           pop;
  logic           pop_valid;

  // Classify each item: header needed, element size, checksum due.
  tfec_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .job_o  (push_job),
    .push_o (push)
  );

  // Decouple acceptance from the byte-serial output.
  tfec_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_job_i  (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .pop_valid_o (pop_valid),
    .pop_job_o   (pop_job)
  );

  // Emit one byte per cycle while the link is not stalled; pop the job on its final byte.
  tfec_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (pop_valid),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule
`default_nettype wire

/* rtl/tfec_front.sv */
// Front end: accept items, track the open frame, turn each item into a job.
`default_nettype none
module tfec_front (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  tfec_in_if.sink         in_i,
  input  wire logic       full_i,
  output tfec_pkg::job_t  job_o,
  output logic            push_o
);

  logic [tfec_pkg::COUNT_BITS-1:0] left_q, left_d, cnt, left_base;
  logic [2:0] kind_q, kind;
  logic       open;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    open      = (left_q != '0);
    cnt       = tfec_pkg::COUNT_BITS'(in_i.element_count);
    kind      = open ? kind_q : in_i.element_kind;
    left_base = open ? left_q : cnt;

    job_o.hdr  = !open;
    job_o.tl   = tfec_pkg::type_code(in_i.element_kind) | 8'(cnt);
    job_o.addr = in_i.target_address;
    job_o.val  = in_i.element_value;

    if (!open && (cnt == '0)) begin
      // Empty frame: header and checksum only.
      job_o.elen   = tfec_pkg::ELEN_NONE;
      left_d       = '0;
      job_o.sum_en = 1'b1;
    end else begin
      job_o.elen   = tfec_pkg::is_short(kind) ? tfec_pkg::ELEN_SHORT
                                              : tfec_pkg::ELEN_LONG;
      left_d       = left_base - 1'b1;
      job_o.sum_en = (left_d == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      kind_q <= '0;
    end else if (push_o) begin
      left_q <= left_d;
      if (!open) begin
        kind_q <= in_i.element_kind;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/tfec_queue.sv */
// Two-entry job queue between front end and serializer.
`default_nettype none
module tfec_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire tfec_pkg::job_t  push_job_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 pop_valid_o,
  output tfec_pkg::job_t       pop_job_o
);

  tfec_pkg::job_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o      = (cnt_q == 2'd2);
  assign pop_valid_o = (cnt_q != 2'd0);
  assign pop_job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/tfec_back.sv */
// Serializer: walk each job byte by byte, keep the running sum, drive the link.
`default_nettype none
module tfec_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            job_valid_i,
  input  wire tfec_pkg::job_t  job_i,
  output logic                 pop_o,
  tfec_out_if.source           out_o
);

  logic [3:0] k_q, hoff, e, nbytes;
  logic [7:0] sum_q, sum_d, byte_d;
  logic [7:0] obyte_q;
  logic       ovalid_q, olast_q, oend_q;
  logic       fire, is_last, is_sum, is_cmd;

  assign out_o.valid       = ovalid_q;
  assign out_o.out_byte    = obyte_q;
  assign out_o.last_of_run = olast_q;
  assign out_o.frame_end   = oend_q;

  always_comb begin
    fire   = job_valid_i && (!ovalid_q || out_o.ready);
    hoff   = job_i.hdr ? tfec_pkg::HDR_BYTES : 4'd0;
    e      = k_q - hoff;
    nbytes = hoff + 4'(job_i.elen) + 4'(job_i.sum_en);
    is_last = (k_q == nbytes - 4'd1);
    is_cmd  = job_i.hdr && (k_q == 4'd0);
    is_sum  = 1'b0;

    if (job_i.hdr && (k_q < tfec_pkg::HDR_BYTES)) begin
      case (k_q[1:0])
        2'd0:    byte_d = tfec_pkg::CMD_BYTE;
        2'd1:    byte_d = job_i.tl;
        default: byte_d = job_i.addr;
      endcase
    end else if (e < 4'(job_i.elen)) begin
      case (e[1:0])
        2'd0:    byte_d = job_i.val[7:0];
        2'd1:    byte_d = job_i.val[15:8];
        2'd2:    byte_d = job_i.val[23:16];
        default: byte_d = job_i.val[31:24];
      endcase
    end else begin
      is_sum = 1'b1;
      byte_d = 8'd0 - sum_q;
    end

    // Restart the sum on the command byte, clear it after the checksum.
    if (is_cmd) begin
      sum_d = byte_d;
    end else if (is_sum) begin
      sum_d = 8'd0;
    end else begin
      sum_d = sum_q + byte_d;
    end

    pop_o = fire && is_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q      <= 4'd0;
      sum_q    <= 8'd0;
      ovalid_q <= 1'b0;
    end else begin
      if (fire) begin
        k_q      <= is_last ? 4'd0 : k_q + 4'd1;
        sum_q    <= sum_d;
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      obyte_q <= byte_d;
      olast_q <= is_last;
      oend_q  <= is_sum;
    end
  end

endmodule
`default_nettype wire

/* test/tfec_frame_checker.sv */
// Frame checker: predicts the link bytes of each accepted item and compares them.
`timescale 1ns / 1ps
module tfec_frame_checker (
  input  logic clk_i,
  input  logic rst_ni,
  tfec_in_if   in_i,
  tfec_out_if  out_i,
  input  logic drain_done_i,
  output int   pending_o,
  output logic checked_o,
  output int   fail_count_o,
  output int   bytes_seen_o,
  output int   frames_seen_o
);
  import tfec_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       frame_end;
  } link_byte_t;

  link_byte_t expected_bytes[$];
  link_byte_t want;

  // Own copy of the encoder state.
  logic [3:0] frame_left;
  logic [7:0] frame_sum;
  logic [2:0] open_kind;

  int mismatches = 0;
  int bytes_seen = 0;
  int frames_seen = 0;

  assign fail_count_o  = mismatches;
  assign bytes_seen_o  = bytes_seen;
  assign frames_seen_o = frames_seen;

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic is_sum);
    link_byte_t e;
    e.data      = b;
    e.run_last  = 1'b0;
    e.frame_end = is_sum;
    expected_bytes.push_back(e);
    if (!is_sum) begin
      frame_sum = frame_sum + b;
    end
  endtask

  task automatic push_checksum();
    push_byte(8'h00 - frame_sum, 1'b1);
    frame_sum = '0;
  endtask

  // Append the link bytes one item produces and flag the last of them.
  task automatic predict_frame_bytes(input logic [2:0] kind, input logic [3:0] count,
                                     input logic [7:0] addr, input logic [31:0] value);
    logic [7:0] hdr_code;
    int         width_bytes;
    if (frame_left == '0) begin
      case (kind)
        KIND_U16: hdr_code = CODE_U16;
        KIND_I16: hdr_code = CODE_I16;
        KIND_U32: hdr_code = CODE_U32;
        KIND_I32: hdr_code = CODE_I32;
        default:  hdr_code = CODE_F32;
      endcase
      hdr_code  = hdr_code | {4'h0, count};
      frame_sum = '0;
      open_kind = kind;
      push_byte(CMD_BYTE, 1'b0);
      push_byte(hdr_code, 1'b0);
      push_byte(addr, 1'b0);
      frame_left = count;
      if (count == '0) begin
        push_checksum();
      end
    end
    if (frame_left != '0) begin
      width_bytes = (open_kind == KIND_U16 || open_kind == KIND_I16) ? 2 : 4;
      for (int i = 0; i < width_bytes; i++) begin
        push_byte(value[8*i +: 8], 1'b0);
      end
      frame_left = frame_left - 4'd1;
      if (frame_left == '0) begin
        push_checksum();
      end
    end
    expected_bytes[expected_bytes.size() - 1].run_last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_bytes.delete();
      frame_left = '0;
      frame_sum  = '0;
      open_kind  = '0;
      pending_o <= 0;
      checked_o <= 1'b0;
    end else begin
      // Compare first: a byte leaving now always belongs to an older item.
      if (out_i.valid && out_i.ready) begin
        bytes_seen++;
        if (out_i.frame_end === 1'b1) begin
          frames_seen++;
        end
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last %b end %b",
                                    out_i.out_byte, out_i.last_of_run, out_i.frame_end));
        end else begin
          want = expected_bytes.pop_front();
          if (out_i.out_byte !== want.data || out_i.last_of_run !== want.run_last ||
              out_i.frame_end !== want.frame_end) begin
            report_mismatch($sformatf("byte %02h last %b end %b, want %02h last %b end %b",
                                      out_i.out_byte, out_i.last_of_run, out_i.frame_end,
                                      want.data, want.run_last, want.frame_end));
          end
        end
      end
      if (in_i.valid && in_i.ready) begin
        predict_frame_bytes(in_i.element_kind, in_i.element_count,
                            in_i.target_address, in_i.element_value);
      end
      if (drain_done_i && !checked_o) begin
        if (expected_bytes.size() != 0) begin
          report_mismatch($sformatf("%0d expected bytes never arrived",
                                    expected_bytes.size()));
        end
        checked_o <= 1'b1;
      end
      pending_o <= expected_bytes.size();
    end
  end

endmodule

/* test/tb_typed_frame_encoder_checksum.sv */
// Testbench top: drives items into the frame encoder, stalls the link, gives the verdict.
`timescale 1ns / 1ps
module tb_typed_frame_encoder_checksum;
  import tfec_pkg::*;

  // Idle cycles tolerated with no item moving on either channel. The longest
  // legitimate quiet stretch is the receiver hold-off below.
  localparam int IDLE_LIMIT      = 4000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_OFF_START  = 600;
  localparam int RANDOM_ITEMS    = 380;
  // Header plus longest element plus checksum, with margin for the pipeline.
  localparam int DRAIN_CYCLES    = 12;

  logic clk;
  logic rst_n;
  logic drain_done;
  logic checked;
  int   pending;
  int   fail_count;
  int   bytes_seen;
  int   frames_seen;
  int   items_sent = 0;
  int   idle_cycles = 0;

  tfec_in_if  in_if ();
  tfec_out_if out_if ();

  typed_frame_encoder_checksum dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  tfec_frame_checker u_frame_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_i          (in_if),
    .out_i         (out_if),
    .drain_done_i  (drain_done),
    .pending_o     (pending),
    .checked_o     (checked),
    .fail_count_o  (fail_count),
    .bytes_seen_o  (bytes_seen),
    .frames_seen_o (frames_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one item and hold it until the encoder takes it. Valid stays high on
  // return so back-to-back items never drop it within a step.
  task automatic send_item(input logic [2:0] kind, input logic [3:0] count,
                           input logic [7:0] addr, input logic [31:0] value);
    in_if.valid          <= 1'b1;
    in_if.element_kind   <= kind;
    in_if.element_count  <= count;
    in_if.target_address <= addr;
    in_if.element_value  <= value;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    items_sent++;
  endtask

  // Random item. Counts lean small so many frames close; kinds cover the
  // unused codes too, and values hit all-zero and all-one now and then.
  task automatic send_random_item();
    logic [3:0]  count;
    logic [31:0] value;
    int          pick;
    count = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
    pick  = $urandom_range(0, 9);
    value = (pick == 0) ? 32'h0000_0000 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
    send_item(3'($urandom_range(0, 7)), count, 8'($urandom_range(0, 255)), value);
  endtask

  // Drop valid for a gap of the given length.
  task automatic idle_gap(input int cycles);
    if (cycles > 0) begin
      in_if.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Drop valid and hold until every predicted byte has left the link.
  task automatic wait_all_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Sender: reset, directed items, a full drain, then random bursts.
  initial begin
    rst_n                <= 1'b0;
    drain_done           <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.element_kind   <= '0;
    in_if.element_count  <= '0;
    in_if.target_address <= '0;
    in_if.element_value  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty frames of every kind code, unused kinds included; the value is
    // ignored and the address alternates between its extremes.
    for (int k = 0; k < 8; k++) begin
      send_item(3'(k), 4'd0, (k % 2 == 1) ? 8'hFF : 8'h00, 32'hFFFF_FFFF);
    end
    // Single short element: header, two bytes and checksum from one item.
    send_item(KIND_U16, 4'd1, 8'hFF, 32'hFFFF_FFFF);
    // Full-length frame. Items after the first carry junk kind, count and
    // address that the encoder must ignore.
    send_item(KIND_I32, 4'd15, 8'hA5, 32'h0000_0000);
    for (int k = 1; k < 15; k++) begin
      send_item(~3'(k), 4'(k), 8'(k * 17), (k % 2 == 1) ? 32'hFFFF_FFFF : $urandom);
    end

    // Let the link run dry before random traffic starts.
    wait_all_results();

    // Bursts of random length; roughly one burst in four runs straight into
    // the next with no gap at all.
    while (items_sent < 24 + RANDOM_ITEMS) begin
      repeat ($urandom_range(1, 16)) send_random_item();
      if ($urandom_range(0, 3) != 0) begin
        idle_gap($urandom_range(1, 10));
      end
    end

    // Drain, let the pipeline settle, then ask the checker for leftovers.
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    drain_done <= 1'b1;
    @(posedge clk);
    while (!checked) @(posedge clk);

    $display("Covered %0d items, %0d link bytes checked, %0d frames closed with a checksum.",
             items_sent, bytes_seen, frames_seen);
    $display("Included empty and full-length frames, all kind codes and a long link stall.");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Receiver: phases of free flow, light and heavy stalling, plus one long
  // hold-off that fills the encoder's queue while the sender keeps offering.
  initial begin
    int  phase_left;
    int  stall_level;
    int  cycle_count;
    bit  hold_done;
    out_if.ready <= 1'b0;
    phase_left  = 0;
    stall_level = 0;
    cycle_count = 0;
    hold_done   = 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!hold_done && cycle_count >= HOLD_OFF_START) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      if (phase_left == 0) begin
        phase_left  = $urandom_range(4, 40);
        stall_level = $urandom_range(0, 2);
      end
      case (stall_level)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= ($urandom_range(0, 2) != 0);
        default: out_if.ready <= ($urandom_range(0, 2) == 0);
      endcase
      phase_left--;
      cycle_count++;
      @(posedge clk);
    end
  end

  // Watchdog: end the run if no item moves on either side for too long.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
